@@ hw/rtl/fbac_pkg.sv @@
// Package for the four-band allpass crossover: types, constants and microcode table.
`default_nettype none
package fbac_pkg;

    localparam int COEF_FIELD_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int NUM_REGS         = 8;
    localparam int REG_INDEX_WIDTH  = 3;
    localparam int SO_DEPTH         = 16;
    localparam int FO_DEPTH         = 11;
    localparam int ST_INDEX_WIDTH   = 4;
    localparam int PC_WIDTH         = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_LOW  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_MID  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    // Micro-operations of the shared unit.
    typedef enum logic [2:0] {
        OP_MAC,   // dst = sat(c + round(k*v))
        OP_MSUB,  // dst = sat(c - round(k*v))
        OP_HALVE, // dst = sat(floor((c + v + 1) / 2))
        OP_SUB,   // dst = sat(c - v)
        OP_END
    } op_t;

    // Source and destination selectors.
    typedef enum logic [1:0] {
        LOC_REG,  // scratch register file
        LOC_SO,   // second-order state
        LOC_FO,   // first-order state
        LOC_ZERO
    } loc_t;

    typedef enum logic [1:0] {
        K_11,
        K_12,
        K_22
    } ksel_t;

    typedef struct packed {
        op_t                       op;
        loc_t                      c_loc;
        logic [ST_INDEX_WIDTH-1:0] c_idx;
        loc_t                      v_loc;
        logic [ST_INDEX_WIDTH-1:0] v_idx;
        loc_t                      d_loc;
        logic [ST_INDEX_WIDTH-1:0] d_idx;
        logic [1:0]                cset;   // 0 low, 1 mid, 2 high
        ksel_t                     ksel;
    } uop_t;

    // Scratch registers.
    localparam logic [3:0] R_X  = 4'd0;
    localparam logic [3:0] R_Y2 = 4'd1;
    localparam logic [3:0] R_Y1 = 4'd2;
    localparam logic [3:0] R_LO = 4'd3;
    localparam logic [3:0] R_HP = 4'd4;
    localparam logic [3:0] R_W  = 4'd5;
    localparam logic [3:0] R_A  = 4'd6;
    localparam logic [3:0] R_B  = 4'd7;
    // Band results are held in R_A/R_B/R_Y2.. are reused; final bands go to
    // dedicated band registers through destination LOC_ZERO with d_idx = band.

    function automatic uop_t mk(op_t op, loc_t cl, logic [3:0] ci, loc_t vl,
                                logic [3:0] vi, loc_t dl, logic [3:0] di,
                                logic [1:0] cs, ksel_t ks);
        uop_t u;
        u.op = op; u.c_loc = cl; u.c_idx = ci; u.v_loc = vl; u.v_idx = vi;
        u.d_loc = dl; u.d_idx = di; u.cset = cs; u.ksel = ks;
        return u;
    endfunction

    // ap2: input register xr, output yr, state s, s+1.
    // ap1: input xr, output yr, state f; uses R_W.
    function automatic uop_t ucode(logic [PC_WIDTH-1:0] pc);
        uop_t u;
        logic [6:0] p;
        p = pc;
        u = mk(OP_END, LOC_ZERO, 4'd0, LOC_ZERO, 4'd0, LOC_ZERO, 4'd0, 2'd0, K_11);
        case (p)
            // ---- mid split on R_X, so 0..3, fo 0..2, coefs mid ----
            7'd0:  u = mk(OP_MAC,  LOC_SO,0,  LOC_REG,R_X, LOC_REG,R_Y2, 2'd1, K_22);
            7'd1:  u = mk(OP_MAC,  LOC_SO,1,  LOC_REG,R_X, LOC_SO,0,    2'd1, K_12);
            7'd2:  u = mk(OP_MSUB, LOC_SO,0,  LOC_REG,R_Y2,LOC_SO,0,    2'd1, K_12);
            7'd3:  u = mk(OP_MSUB, LOC_REG,R_X,LOC_REG,R_Y2,LOC_SO,1,   2'd1, K_22);
            7'd4:  u = mk(OP_MSUB, LOC_REG,R_X,LOC_FO,0,  LOC_REG,R_W,  2'd1, K_11);
            7'd5:  u = mk(OP_MAC,  LOC_FO,0,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd1, K_11);
            7'd6:  u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,0,    2'd1, K_11);
            7'd7:  u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_REG,R_LO,2'd1, K_11);
            7'd8:  u = mk(OP_MSUB, LOC_REG,R_Y2,LOC_FO,1, LOC_REG,R_W,  2'd1, K_11);
            7'd9:  u = mk(OP_MAC,  LOC_FO,1,  LOC_REG,R_W, LOC_REG,R_HP, 2'd1, K_11);
            7'd10: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,1,    2'd1, K_11);
            7'd11: u = mk(OP_MAC,  LOC_SO,2,  LOC_REG,R_LO,LOC_REG,R_Y2, 2'd1, K_22);
            7'd12: u = mk(OP_MAC,  LOC_SO,3,  LOC_REG,R_LO,LOC_SO,2,    2'd1, K_12);
            7'd13: u = mk(OP_MSUB, LOC_SO,2,  LOC_REG,R_Y2,LOC_SO,2,    2'd1, K_12);
            7'd14: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_REG,R_Y2,LOC_SO,3,  2'd1, K_22);
            7'd15: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_FO,2, LOC_REG,R_W,  2'd1, K_11);
            7'd16: u = mk(OP_MAC,  LOC_FO,2,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd1, K_11);
            7'd17: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,2,    2'd1, K_11);
            7'd18: u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_REG,R_A,2'd1, K_11);
            7'd19: u = mk(OP_SUB,  LOC_REG,R_HP,LOC_REG,R_A,LOC_REG,R_B, 2'd1, K_11);
            // ---- compensate low half R_A: so 12,13, fo 9, coefs high ----
            7'd20: u = mk(OP_MAC,  LOC_SO,12, LOC_REG,R_A, LOC_REG,R_Y2, 2'd2, K_22);
            7'd21: u = mk(OP_MAC,  LOC_SO,13, LOC_REG,R_A, LOC_SO,12,   2'd2, K_12);
            7'd22: u = mk(OP_MSUB, LOC_SO,12, LOC_REG,R_Y2,LOC_SO,12,   2'd2, K_12);
            7'd23: u = mk(OP_MSUB, LOC_REG,R_A,LOC_REG,R_Y2,LOC_SO,13,  2'd2, K_22);
            7'd24: u = mk(OP_MSUB, LOC_REG,R_Y2,LOC_FO,9, LOC_REG,R_W,  2'd2, K_11);
            7'd25: u = mk(OP_MAC,  LOC_FO,9,  LOC_REG,R_W, LOC_REG,R_A,  2'd2, K_11);
            7'd26: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,9,    2'd2, K_11);
            // ---- compensate high half R_B: so 14,15, fo 10, coefs low ----
            7'd27: u = mk(OP_MAC,  LOC_SO,14, LOC_REG,R_B, LOC_REG,R_Y2, 2'd0, K_22);
            7'd28: u = mk(OP_MAC,  LOC_SO,15, LOC_REG,R_B, LOC_SO,14,   2'd0, K_12);
            7'd29: u = mk(OP_MSUB, LOC_SO,14, LOC_REG,R_Y2,LOC_SO,14,   2'd0, K_12);
            7'd30: u = mk(OP_MSUB, LOC_REG,R_B,LOC_REG,R_Y2,LOC_SO,15,  2'd0, K_22);
            7'd31: u = mk(OP_MSUB, LOC_REG,R_Y2,LOC_FO,10,LOC_REG,R_W,  2'd0, K_11);
            7'd32: u = mk(OP_MAC,  LOC_FO,10, LOC_REG,R_W, LOC_REG,R_B,  2'd0, K_11);
            7'd33: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,10,   2'd0, K_11);
            // ---- low split on R_A: so 4..7, fo 3..5, coefs low; bands 0,1 ----
            7'd34: u = mk(OP_MAC,  LOC_SO,4,  LOC_REG,R_A, LOC_REG,R_Y2, 2'd0, K_22);
            7'd35: u = mk(OP_MAC,  LOC_SO,5,  LOC_REG,R_A, LOC_SO,4,    2'd0, K_12);
            7'd36: u = mk(OP_MSUB, LOC_SO,4,  LOC_REG,R_Y2,LOC_SO,4,    2'd0, K_12);
            7'd37: u = mk(OP_MSUB, LOC_REG,R_A,LOC_REG,R_Y2,LOC_SO,5,   2'd0, K_22);
            7'd38: u = mk(OP_MSUB, LOC_REG,R_A,LOC_FO,3, LOC_REG,R_W,   2'd0, K_11);
            7'd39: u = mk(OP_MAC,  LOC_FO,3,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd0, K_11);
            7'd40: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,3,    2'd0, K_11);
            7'd41: u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_REG,R_LO,2'd0, K_11);
            7'd42: u = mk(OP_MSUB, LOC_REG,R_Y2,LOC_FO,4, LOC_REG,R_W,  2'd0, K_11);
            7'd43: u = mk(OP_MAC,  LOC_FO,4,  LOC_REG,R_W, LOC_REG,R_HP, 2'd0, K_11);
            7'd44: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,4,    2'd0, K_11);
            7'd45: u = mk(OP_MAC,  LOC_SO,6,  LOC_REG,R_LO,LOC_REG,R_Y2, 2'd0, K_22);
            7'd46: u = mk(OP_MAC,  LOC_SO,7,  LOC_REG,R_LO,LOC_SO,6,    2'd0, K_12);
            7'd47: u = mk(OP_MSUB, LOC_SO,6,  LOC_REG,R_Y2,LOC_SO,6,    2'd0, K_12);
            7'd48: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_REG,R_Y2,LOC_SO,7,  2'd0, K_22);
            7'd49: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_FO,5, LOC_REG,R_W,  2'd0, K_11);
            7'd50: u = mk(OP_MAC,  LOC_FO,5,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd0, K_11);
            7'd51: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,5,    2'd0, K_11);
            7'd52: u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_ZERO,0, 2'd0, K_11);
            7'd53: u = mk(OP_SUB,  LOC_REG,R_HP,LOC_ZERO,0,LOC_ZERO,1,   2'd0, K_11);
            // ---- high split on R_B: so 8..11, fo 6..8, coefs high; bands 2,3 ----
            7'd54: u = mk(OP_MAC,  LOC_SO,8,  LOC_REG,R_B, LOC_REG,R_Y2, 2'd2, K_22);
            7'd55: u = mk(OP_MAC,  LOC_SO,9,  LOC_REG,R_B, LOC_SO,8,    2'd2, K_12);
            7'd56: u = mk(OP_MSUB, LOC_SO,8,  LOC_REG,R_Y2,LOC_SO,8,    2'd2, K_12);
            7'd57: u = mk(OP_MSUB, LOC_REG,R_B,LOC_REG,R_Y2,LOC_SO,9,   2'd2, K_22);
            7'd58: u = mk(OP_MSUB, LOC_REG,R_B,LOC_FO,6, LOC_REG,R_W,   2'd2, K_11);
            7'd59: u = mk(OP_MAC,  LOC_FO,6,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd2, K_11);
            7'd60: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,6,    2'd2, K_11);
            7'd61: u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_REG,R_LO,2'd2, K_11);
            7'd62: u = mk(OP_MSUB, LOC_REG,R_Y2,LOC_FO,7, LOC_REG,R_W,  2'd2, K_11);
            7'd63: u = mk(OP_MAC,  LOC_FO,7,  LOC_REG,R_W, LOC_REG,R_HP, 2'd2, K_11);
            7'd64: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,7,    2'd2, K_11);
            7'd65: u = mk(OP_MAC,  LOC_SO,10, LOC_REG,R_LO,LOC_REG,R_Y2, 2'd2, K_22);
            7'd66: u = mk(OP_MAC,  LOC_SO,11, LOC_REG,R_LO,LOC_SO,10,   2'd2, K_12);
            7'd67: u = mk(OP_MSUB, LOC_SO,10, LOC_REG,R_Y2,LOC_SO,10,   2'd2, K_12);
            7'd68: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_REG,R_Y2,LOC_SO,11, 2'd2, K_22);
            7'd69: u = mk(OP_MSUB, LOC_REG,R_LO,LOC_FO,8, LOC_REG,R_W,  2'd2, K_11);
            7'd70: u = mk(OP_MAC,  LOC_FO,8,  LOC_REG,R_W, LOC_REG,R_Y1, 2'd2, K_11);
            7'd71: u = mk(OP_MAC,  LOC_REG,R_W,LOC_ZERO,0, LOC_FO,8,    2'd2, K_11);
            7'd72: u = mk(OP_HALVE,LOC_REG,R_Y2,LOC_REG,R_Y1,LOC_ZERO,2, 2'd2, K_11);
            7'd73: u = mk(OP_SUB,  LOC_REG,R_HP,LOC_ZERO,2,LOC_ZERO,3,   2'd2, K_11);
            default: u = mk(OP_END, LOC_ZERO,0, LOC_ZERO,0, LOC_ZERO,0, 2'd0, K_11);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/four_band_allpass_crossover_unit.sv @@
// Four-band allpass crossover: microcoded sequencer around one shared multiply-add unit.
// Each sample runs a fixed 74-step microprogram, one step per cycle through a single
// coefficient multiplier and saturating adder, then the end-of-program step and the load
// of the output register. s_tready stays low from acceptance until that load,
// and longer while an earlier result still waits in the output register,
// because the new result is only loaded once that register is free. Filter state lives
// in two small register files that reset clears to zero; the three coefficient
// registers are written through cfg_* only while the block is idle.
`default_nettype none
module four_band_allpass_crossover_unit #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int STATE_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 18
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample_in
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // band_lowest, band_low_mid, band_high_mid, band_highest
    output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [fbac_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire  [3*fbac_pkg::COEF_FIELD_WIDTH-1:0] cfg_data
);
    localparam int CW    = fbac_pkg::COEF_FIELD_WIDTH;
    localparam int SW    = STATE_WIDTH;
    localparam int PW    = SW + CW + 2;
    localparam int MDW   = ((4*SAMPLE_WIDTH+7)/8)*8;
    localparam int PCW   = fbac_pkg::PC_WIDTH;

    fbac_pkg::state_t state_reg, state_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [3*CW-1:0] coef_reg [3];
    logic signed [SW-1:0] so_reg [fbac_pkg::SO_DEPTH];
    logic signed [SW-1:0] fo_reg [fbac_pkg::FO_DEPTH];
    logic signed [SW-1:0] rf_reg [fbac_pkg::NUM_REGS];
    logic signed [SW-1:0] band_reg [4];
    logic [MDW-1:0] out_reg;
    logic out_valid_reg;

    fbac_pkg::uop_t u;
    logic signed [SW-1:0] c_val, v_val, res;
    logic signed [CW-1:0] k_val;
    logic [3*CW-1:0] cs;
    logic signed [PW-1:0] prod, rnd, sum;
    logic signed [SW+1:0] wide;
    logic do_step;

    assign u = fbac_pkg::ucode(pc_reg);
    assign cfg_ready = (state_reg == fbac_pkg::ST_IDLE);
    assign s_tready  = (state_reg == fbac_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign do_step   = (state_reg == fbac_pkg::ST_RUN) && (u.op != fbac_pkg::OP_END);

    function automatic logic signed [SW-1:0] rd(fbac_pkg::loc_t l, logic [3:0] i,
        logic signed [SW-1:0] so [fbac_pkg::SO_DEPTH],
        logic signed [SW-1:0] fo [fbac_pkg::FO_DEPTH],
        logic signed [SW-1:0] rf [fbac_pkg::NUM_REGS],
        logic signed [SW-1:0] bd [4]);
        logic signed [SW-1:0] r;
        case (l)
            fbac_pkg::LOC_REG: r = rf[i[2:0]];
            fbac_pkg::LOC_SO:  r = so[i];
            fbac_pkg::LOC_FO:  r = (i < 4'(fbac_pkg::FO_DEPTH)) ? fo[i] : '0;
            default:           r = bd[i[1:0]];
        endcase
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sat(logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi, lo;
        hi = PW'({1'b0, {(SW-1){1'b1}}});
        lo = -hi - PW'(1);
        if (v > hi)      return hi[SW-1:0];
        else if (v < lo) return lo[SW-1:0];
        else             return v[SW-1:0];
    endfunction

    always_comb
    begin
        // LOC_ZERO as a source reads the band registers (used for the high-part subtract).
        c_val = rd(u.c_loc, u.c_idx, so_reg, fo_reg, rf_reg, band_reg);
        v_val = rd(u.v_loc, u.v_idx, so_reg, fo_reg, rf_reg, band_reg);
        case (u.cset)
            2'd0:    cs = coef_reg[0];
            2'd1:    cs = coef_reg[1];
            default: cs = coef_reg[2];
        endcase
        case (u.ksel)
            fbac_pkg::K_12: k_val = cs[2*CW-1:CW];
            fbac_pkg::K_22: k_val = cs[3*CW-1:2*CW];
            default:        k_val = cs[CW-1:0];
        endcase
        // Exact floor(k*v/2^F + 1/2), which matches the split-product form.
        prod = PW'(k_val) * PW'(v_val);
        rnd  = (prod + (PW'(1) <<< (COEF_FRAC_BITS-1))) >>> COEF_FRAC_BITS;
        wide = '0;
        case (u.op)
            fbac_pkg::OP_MAC:   sum = PW'(c_val) + rnd;
            fbac_pkg::OP_MSUB:  sum = PW'(c_val) - rnd;
            fbac_pkg::OP_HALVE:
            begin
                wide = ((SW+2)'(c_val) + (SW+2)'(v_val) + (SW+2)'(1)) >>> 1;
                sum  = PW'(wide);
            end
            fbac_pkg::OP_SUB:   sum = PW'(c_val) - PW'(v_val);
            default:            sum = '0;
        endcase
        res = sat(sum);
    end

    // A write-back of the scratch W into first-order state is a plain copy.
    logic signed [SW-1:0] wb;
    assign wb = (u.v_loc == fbac_pkg::LOC_ZERO && u.op == fbac_pkg::OP_MAC &&
                 u.d_loc == fbac_pkg::LOC_FO) ? c_val : res;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            fbac_pkg::ST_IDLE:
            begin
                pc_next = '0;
                if (s_tvalid) state_next = fbac_pkg::ST_RUN;
            end
            fbac_pkg::ST_RUN:
            begin
                if (u.op == fbac_pkg::OP_END) state_next = fbac_pkg::ST_OUT;
                else pc_next = pc_reg + PCW'(1);
            end
            fbac_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready) state_next = fbac_pkg::ST_IDLE;
            end
            default: state_next = fbac_pkg::ST_IDLE;
        endcase
    end

    function automatic logic [SAMPLE_WIDTH-1:0] osat(logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        lo = -hi - SW'(1);
        if (v > hi)      return hi[SAMPLE_WIDTH-1:0];
        else if (v < lo) return lo[SAMPLE_WIDTH-1:0];
        else             return v[SAMPLE_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbac_pkg::ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) coef_reg[i] <= '0;
            for (int i = 0; i < fbac_pkg::SO_DEPTH; i++) so_reg[i] <= '0;
            for (int i = 0; i < fbac_pkg::FO_DEPTH; i++) fo_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fbac_pkg::CFG_COEF_LOW:  coef_reg[0] <= cfg_data;
                    fbac_pkg::CFG_COEF_MID:  coef_reg[1] <= cfg_data;
                    fbac_pkg::CFG_COEF_HIGH: coef_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (do_step && u.d_loc == fbac_pkg::LOC_SO) so_reg[u.d_idx] <= wb;
            if (do_step && u.d_loc == fbac_pkg::LOC_FO &&
                u.d_idx < 4'(fbac_pkg::FO_DEPTH))
                fo_reg[u.d_idx] <= wb;
            // A new result may replace one that is taken in the same cycle.
            if (state_reg == fbac_pkg::ST_OUT && state_next == fbac_pkg::ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            rf_reg[fbac_pkg::R_X[2:0]] <= SW'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
        if (do_step && u.d_loc == fbac_pkg::LOC_REG) rf_reg[u.d_idx[2:0]] <= res;
        if (do_step && u.d_loc == fbac_pkg::LOC_ZERO) band_reg[u.d_idx[1:0]] <= res;
        if (state_reg == fbac_pkg::ST_OUT && state_next == fbac_pkg::ST_IDLE)
            out_reg <= MDW'({osat(band_reg[3]), osat(band_reg[2]),
                             osat(band_reg[1]), osat(band_reg[0])});
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbac_pkg::ST_RUN) |-> !s_tready)
        else $error("input ready while the sequencer runs");
    a_start_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (pc_reg == '0 && state_reg == fbac_pkg::ST_RUN))
        else $error("sequencer did not start at step zero");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the four-band allpass crossover unit.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 24;
    localparam int STW = 32;
    localparam int FRAC = 18;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [fbac_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SW-1:0] b [4];
    } bands_t;

    typedef struct {
        int                   coef_step;  // coefficient setting the row runs under
        logic signed [SW-1:0] sample;
        bit                   known;
        logic signed [SW-1:0] b [4];
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;   // sample_in
    logic m_tvalid;
    logic m_tready = 1'b0;
    // band_lowest, band_low_mid, band_high_mid, band_highest
    logic [95:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fbac_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [3*fbac_pkg::COEF_FIELD_WIDTH-1:0] cfg_data = '0;

    four_band_allpass_crossover_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic [59:0] coef_reg [3];
    longint so_state [16];
    longint fo_state [11];
    bands_t band_queue [$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;

    function automatic longint sat(longint v, int w);
        longint lim;
        lim = longint'(1) <<< (w - 1);
        if (v >= lim)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint coef_field(int set, int j);
        logic signed [19:0] f;
        f = coef_reg[set][20*j +: 20];
        return longint'(f);
    endfunction

    function automatic longint mac(longint c, longint k, longint v);
        return sat(c + ((k * v + (longint'(1) <<< (FRAC - 1))) >>> FRAC), STW);
    endfunction

    function automatic longint msub(longint c, longint k, longint v);
        return sat(c - ((k * v + (longint'(1) <<< (FRAC - 1))) >>> FRAC), STW);
    endfunction

    function automatic longint halve(longint a, longint b);
        return sat((a + b + 1) >>> 1, STW);
    endfunction

    // Second-order lattice section on state entries si and si+1.
    function automatic longint lattice2(longint x, int si, int set);
        longint y;
        y = mac(so_state[si], coef_field(set, 2), x);
        so_state[si] = mac(so_state[si+1], coef_field(set, 1), x);
        so_state[si] = msub(so_state[si], coef_field(set, 1), y);
        so_state[si+1] = msub(x, coef_field(set, 2), y);
        return y;
    endfunction

    function automatic longint lattice1(longint x, int fi, int set);
        longint w;
        longint y;
        w = msub(x, coef_field(set, 0), fo_state[fi]);
        y = mac(fo_state[fi], coef_field(set, 0), w);
        fo_state[fi] = w;
        return y;
    endfunction

    function automatic void band_split(longint x, int si, int fi, int set,
                                       output longint lo, output longint hi);
        longint y2;
        longint y1;
        longint low;
        longint hp;
        y2 = lattice2(x, si, set);
        y1 = lattice1(x, fi, set);
        low = halve(y2, y1);
        hp = lattice1(y2, fi + 1, set);
        y2 = lattice2(low, si + 2, set);
        y1 = lattice1(low, fi + 2, set);
        low = halve(y2, y1);
        lo = low;
        hi = sat(hp - low, STW);
    endfunction

    // Sets: 0 low, 1 mid, 2 high.
    function automatic bands_t crossover_predict(logic signed [SW-1:0] sample);
        longint lh;
        longint hh;
        longint v [4];
        bands_t r;
        band_split(longint'(sample), 0, 0, 1, lh, hh);
        lh = lattice1(lattice2(lh, 12, 2), 9, 2);
        hh = lattice1(lattice2(hh, 14, 0), 10, 0);
        band_split(lh, 4, 3, 0, v[0], v[1]);
        band_split(hh, 8, 6, 2, v[2], v[3]);
        for (int i = 0; i < 4; i++)
            r.b[i] = sat(v[i], SW);
        return r;
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_sample(logic signed [SW-1:0] sample, bit known, bands_t typed);
        int gap;
        bands_t predicted;
        gap = random_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        do @(posedge clk); while (!s_tready);
        predicted = crossover_predict(sample);
        band_queue.push_back(known ? typed : predicted);
    endtask

    task automatic write_coef(logic [fbac_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [59:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx != CFG_UNUSED)
            coef_reg[idx] = value;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (band_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [59:0] random_coefs(bit stable);
        logic [59:0] v;
        for (int j = 0; j < 3; j++)
            v[20*j +: 20] = stable ? 20'($urandom_range(0, 400000) - 200000)
                                   : 20'($urandom);
        return v;
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return SW'($urandom);
        if (r < 9)
            return SW'($urandom_range(0, 8192) - 4096);
        return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endfunction

    task automatic set_coefs(logic [59:0] lo, logic [59:0] mid, logic [59:0] hi);
        wait_idle();
        write_coef(fbac_pkg::CFG_COEF_LOW, lo);
        write_coef(fbac_pkg::CFG_COEF_MID, mid);
        write_coef(fbac_pkg::CFG_COEF_HIGH, hi);
    endtask

    // Output side: random back-pressure, none in burst mode.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (burst_mode)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) < 60) ||
                        (m_tready && $urandom_range(0, 99) < 10);
    end

    always @(posedge clk)
    begin
        bands_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (band_queue.size() == 0)
            begin
                $display("unexpected result transaction at %0t", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = band_queue.pop_front();
                for (int i = 0; i < 4; i++)
                    if ($signed(m_tdata[24*i +: 24]) !== want.b[i])
                        report_mismatch($sformatf("band %0d", i),
                                        longint'($signed(m_tdata[24*i +: 24])),
                                        longint'(want.b[i]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        bands_t typed;
        int step;
        logic signed [SW-1:0] edge_vals [8];

        for (int i = 0; i < 3; i++)
            coef_reg[i] = '0;
        for (int i = 0; i < 16; i++)
            so_state[i] = 0;
        for (int i = 0; i < 11; i++)
            fo_state[i] = 0;

        edge_vals = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, -24'sd1,
                      24'sd1, 24'sh555555, 24'shAAAAAA, 24'sh7FFFFF};
        // With zero coefficients and cleared state the first sample gives silence.
        row.coef_step = 0;
        row.sample = 24'sh7FFFFF;
        row.known = 1'b1;
        row.b = '{default: '0};
        rows.push_back(row);
        row.known = 1'b0;
        for (step = 0; step < 3; step++)
            for (int i = (step == 0) ? 1 : 0; i < 8; i++)
            begin
                row.coef_step = step;
                row.sample = edge_vals[i];
                rows.push_back(row);
            end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out-of-range index must leave every register alone.
        write_coef(CFG_UNUSED, '1);
        step = 0;
        foreach (rows[n])
        begin
            if (rows[n].coef_step != step)
            begin
                step = rows[n].coef_step;
                if (step == 1)
                    set_coefs({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}});
                else
                    set_coefs({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}});
            end
            typed.b = rows[n].b;
            send_sample(rows[n].sample, rows[n].known, typed);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            set_coefs(random_coefs(phase % 3 != 2), random_coefs(phase % 3 != 2),
                      random_coefs(phase % 3 != 2));
            if (phase == 3)
                write_coef(CFG_UNUSED, random_coefs(1'b0));
            for (int n = 0; n < 172; n++)
            begin
                if (n % 40 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                typed.b = '{default: '0};
                send_sample(random_sample(), 1'b0, typed);
            end
        end
        burst_mode = 1'b0;

        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
